/* hdl/hpgl_pkg.sv */
// Shared types and constants of the HSV palette gradient lookup.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package hpgl_pkg;

	localparam int COUNT_W      = 5;
	localparam int POS_W        = 24;
	localparam int IDX_W        = 4;
	localparam int HUE_W        = 16;
	localparam int CH_W         = 8;
	localparam int FRAC_W       = 16;
	localparam int MIR_W        = FRAC_W + 1;
	localparam int QUEUE_DEPTH  = 2;
	localparam int STORE_LIMIT  = 16;

	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_WRITE  = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [POS_W-1:0]  position;
		logic [IDX_W-1:0]  entry_index;
		logic [HUE_W-1:0]  entry_hue;
		logic [CH_W-1:0]   entry_sat;
		logic [CH_W-1:0]   entry_val;
	} hpgl_req_t;

	typedef struct packed {
		logic [HUE_W-1:0] color_hue;
		logic [CH_W-1:0]  color_sat;
		logic [CH_W-1:0]  color_val;
	} hpgl_color_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [CH_W-1:0]  sat;
		logic [CH_W-1:0]  val;
	} hpgl_entry_t;

	typedef enum logic [1:0] {
		KIND_LOOKUP = 2'd0,
		KIND_WRITE  = 2'd1,
		KIND_BLACK  = 2'd2
	} hpgl_kind_t;

	// One classified item as it waits between the front and the back.
	typedef struct packed {
		hpgl_kind_t         kind;
		logic [COUNT_W-1:0] count;
		logic [MIR_W-1:0]   frac;
		logic [IDX_W-1:0]   entry_index;
		hpgl_entry_t        entry;
	} hpgl_qitem_t;

endpackage

`default_nettype wire

/* hdl/hpgl_front.sv */
// Front of the palette lookup: holds the entry count register, accepts items
// and classifies them for the queue. Depends on hpgl_pkg.
`default_nettype none

module hpgl_front #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [hpgl_pkg::COUNT_W-1:0]    cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire hpgl_pkg::hpgl_req_t             in_data,
	output logic                                 q_push,
	output hpgl_pkg::hpgl_qitem_t                q_item,
	input  wire logic                            q_full
);
	import hpgl_pkg::*;

	logic [COUNT_W-1:0] entry_count_q;
	logic [COUNT_W-1:0] count_eff;
	logic [FRAC_W-1:0]  frac_raw;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			entry_count_q <= cfg_data;
		end
	end

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	always_comb begin
		if (32'(entry_count_q) > MAX_ENTRIES) begin
			count_eff = COUNT_W'(MAX_ENTRIES);
		end else begin
			count_eff = entry_count_q;
		end
	end

	assign frac_raw = in_data.position[FRAC_W-1:0];

	always_comb begin
		q_item.count       = count_eff;
		q_item.entry_index = in_data.entry_index;
		q_item.entry.hue   = in_data.entry_hue;
		q_item.entry.sat   = in_data.entry_sat;
		q_item.entry.val   = in_data.entry_val;
		// An odd integer part runs the gradient backward.
		if (in_data.position[FRAC_W]) begin
			q_item.frac = MIR_W'(1 << FRAC_W) - {1'b0, frac_raw};
		end else begin
			q_item.frac = {1'b0, frac_raw};
		end
		if (in_data.req_type == REQ_WRITE) begin
			q_item.kind = KIND_WRITE;
		end else if (count_eff == '0) begin
			q_item.kind = KIND_BLACK;
		end else begin
			q_item.kind = KIND_LOOKUP;
		end
	end

endmodule

`default_nettype wire

/* hdl/hpgl_queue.sv */
// Short queue between the front and the back of the palette lookup.
// Depends on hpgl_pkg.
`default_nettype none

module hpgl_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire hpgl_pkg::hpgl_qitem_t  push_item,
	output logic                        full,
	input  wire logic                   pop,
	output hpgl_pkg::hpgl_qitem_t       head,
	output logic                        empty
);
	import hpgl_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	hpgl_qitem_t       slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/hpgl_back.sv */
// Back of the palette lookup: palette memory, index scaling and the hue,
// saturation and value blends, ending in the output register. Depends on hpgl_pkg.
`default_nettype none

module hpgl_back #(
	parameter int DEPTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire hpgl_pkg::hpgl_qitem_t  q_head,
	input  wire logic                   q_empty,
	output logic                        q_pop,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output hpgl_pkg::hpgl_color_t       out_data
);
	import hpgl_pkg::*;

	localparam int AW    = $clog2(DEPTH);
	localparam int P_W   = MIR_W + COUNT_W;
	localparam int SA_W  = CH_W + MIR_W;
	localparam int SB_W  = CH_W + FRAC_W;
	localparam int SUM_W = SA_W + 1;
	localparam int HP_W  = 2 * HUE_W;
	localparam int HN_W  = HP_W + 2;

	hpgl_entry_t mem [DEPTH];

	logic                adv;
	logic                wr_en;
	logic [P_W-1:0]      p_raw;
	logic [P_W-1:0]      p_lim;
	logic [P_W-1:0]      p_clamped;
	logic [COUNT_W-1:0]  idx_b0;
	logic [COUNT_W:0]    nxt_inc;
	logic [COUNT_W-1:0]  nxt_b0;

	logic                vld_s1;
	logic                black_s1;
	logic [COUNT_W-1:0]  idx_s1;
	logic [COUNT_W-1:0]  nxt_s1;
	logic [FRAC_W-1:0]   w_s1;

	logic                vld_s2;
	logic                black_s2;
	hpgl_entry_t         e0_s2;
	hpgl_entry_t         e1_s2;
	logic [FRAC_W-1:0]   w_s2;
	logic [MIR_W-1:0]    wn_b2;
	logic [HUE_W-1:0]    db_b2;

	logic                vld_s3;
	logic                black_s3;
	logic [HUE_W-1:0]    h0_s3;
	logic [MIR_W-1:0]    wn_s3;
	logic [HP_W-1:0]     prod_h_s3;
	logic [SA_W-1:0]     pa_sat_s3;
	logic [SB_W-1:0]     pb_sat_s3;
	logic [SA_W-1:0]     pa_val_s3;
	logic [SB_W-1:0]     pb_val_s3;

	logic [HN_W-1:0]     hnum_b3;
	logic [SUM_W-1:0]    sat_sum_b3;
	logic [SUM_W-1:0]    val_sum_b3;
	hpgl_color_t         color_b3;

	logic                out_valid_q;
	hpgl_color_t         out_data_q;

	// The whole back moves together; it only holds while a result waits.
	assign adv   = !out_valid_q || out_ready;
	assign q_pop = !q_empty && adv;
	assign wr_en = q_pop && (q_head.kind == KIND_WRITE)
		&& (32'(q_head.entry_index) < DEPTH);

	// Scale the mirrored fraction by the count. Only a fully mirrored fraction
	// reaches the end, and it is pulled back onto the last entry.
	always_comb begin
		p_raw = P_W'(q_head.frac) * P_W'(q_head.count);
		p_lim = P_W'(q_head.count) << FRAC_W;
		if (p_raw >= p_lim) begin
			p_clamped = p_lim - 1'b1;
		end else begin
			p_clamped = p_raw;
		end
		idx_b0  = p_clamped[FRAC_W +: COUNT_W];
		nxt_inc = {1'b0, idx_b0} + 1'b1;
		if (nxt_inc >= {1'b0, q_head.count}) begin
			nxt_b0 = '0;
		end else begin
			nxt_b0 = nxt_inc[COUNT_W-1:0];
		end
	end

	// A write lands at the edge where it leaves the queue, so every lookup
	// behind it reads the new entry.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[q_head.entry_index[AW-1:0]] <= q_head.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			if (q_pop) begin
				case (q_head.kind)
					KIND_LOOKUP: vld_s1 <= 1'b1;
					KIND_BLACK:  vld_s1 <= 1'b1;
					KIND_WRITE:  vld_s1 <= 1'b0;
					default:     vld_s1 <= 1'b0;
				endcase
			end else begin
				vld_s1  <= 1'b0;
			end
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			out_valid_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			black_s1   <= (q_head.kind == KIND_BLACK);
			idx_s1     <= idx_b0;
			nxt_s1     <= nxt_b0;
			w_s1       <= p_clamped[FRAC_W-1:0];

			black_s2   <= black_s1;
			e0_s2      <= mem[idx_s1[AW-1:0]];
			e1_s2      <= mem[nxt_s1[AW-1:0]];
			w_s2       <= w_s1;

			black_s3   <= black_s2;
			h0_s3      <= e0_s2.hue;
			wn_s3      <= wn_b2;
			prod_h_s3  <= HP_W'(db_b2) * HP_W'(w_s2);
			pa_sat_s3  <= SA_W'(e0_s2.sat) * SA_W'(wn_b2);
			pb_sat_s3  <= SB_W'(e1_s2.sat) * SB_W'(w_s2);
			pa_val_s3  <= SA_W'(e0_s2.val) * SA_W'(wn_b2);
			pb_val_s3  <= SB_W'(e1_s2.val) * SB_W'(w_s2);

			out_data_q <= color_b3;
		end
	end

	// Hue difference biased by half a turn, so the blend takes the short arc
	// and an exact half turn goes downward.
	assign wn_b2 = MIR_W'(1 << FRAC_W) - {1'b0, w_s2};
	assign db_b2 = (e1_s2.hue - e0_s2.hue) ^ HUE_W'(1 << (HUE_W - 1));

	always_comb begin
		hnum_b3    = HN_W'(prod_h_s3) + (HN_W'(wn_s3) << (FRAC_W - 1))
			+ HN_W'(1 << (FRAC_W - 1));
		sat_sum_b3 = SUM_W'(pa_sat_s3) + SUM_W'(pb_sat_s3) + SUM_W'(1 << (FRAC_W - 1));
		val_sum_b3 = SUM_W'(pa_val_s3) + SUM_W'(pb_val_s3) + SUM_W'(1 << (FRAC_W - 1));
		if (black_s3) begin
			color_b3 = '0;
		end else begin
			color_b3.color_hue = h0_s3 + hnum_b3[FRAC_W +: HUE_W]
				+ HUE_W'(1 << (HUE_W - 1));
			color_b3.color_sat = sat_sum_b3[FRAC_W +: CH_W];
			color_b3.color_val = val_sum_b3[FRAC_W +: CH_W];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTH
	a_nxt_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !black_s1) |-> (nxt_s1 == '0 || nxt_s1 == idx_s1 + 1'b1))
		else $error("next entry is neither the following entry nor entry zero");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv) |=> (vld_s1 && $stable(idx_s1) && $stable(w_s1)))
		else $error("stage one changed while the back was stalled");

	a_out_from_s3: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(vld_s3))
		else $error("result appeared without an item in the last blend stage");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(q_empty && adv) |=> !vld_s1)
		else $error("stage one filled from an empty queue");
`endif

endmodule

`default_nettype wire

/* hdl/hsv_palette_gradient_lookup_top.sv */
// HSV palette gradient lookup, top level: front, queue and back.
// Depends on hpgl_pkg, hpgl_front, hpgl_queue and hpgl_back.
//
// Usage. Items enter on in_valid/in_ready/in_data. A write item stores one
// palette entry and gives no result; a lookup item gives one result on
// out_valid/out_ready/out_data, in the order the items were taken. The entry
// count is written on cfg_valid/cfg_ready/cfg_data, which is always ready;
// write it only while no item is in flight.
// A lookup passes the queue with index scaling, the palette read, the blend
// products and the blend sums into the output register. Throughput is one
// item per cycle while the receiver takes results, set by the single write
// and two read ports of the palette memory, which serve one item each
// cycle. When the receiver stalls, the back holds as a whole; the two-entry
// queue keeps accepting until it is full, and then in_ready drops.
// Reset clears the entry count to zero (lookups then give black) and empties
// the pipeline; palette entries hold no defined value until written.
`default_nettype none

module hsv_palette_gradient_lookup_top #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [hpgl_pkg::COUNT_W-1:0]  cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire hpgl_pkg::hpgl_req_t           in_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output hpgl_pkg::hpgl_color_t              out_data
);
	import hpgl_pkg::*;

	// Write indexes are four bits wide, so no more entries can be filled.
	localparam int DEPTH = (MAX_ENTRIES > STORE_LIMIT) ? STORE_LIMIT : MAX_ENTRIES;

	logic        q_push;
	logic        q_full;
	logic        q_pop;
	logic        q_empty;
	hpgl_qitem_t q_in;
	hpgl_qitem_t q_head;

	hpgl_front #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.q_push    (q_push),
		.q_item    (q_in),
		.q_full    (q_full)
	);

	hpgl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	hpgl_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_head    (q_head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench of the HSV palette gradient lookup top level.
// Depends on hpgl_pkg and hsv_palette_gradient_lookup_top; results are predicted here.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hpgl_pkg::*;

	localparam int NUM_SLOTS     = STORE_LIMIT;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_ITEMS   = 120;
	localparam int NUM_PHASES    = 8;
	localparam int HOLD_CYCLES   = 300;
	localparam longint CYCLE_LIMIT = 200000;

	typedef struct {
		logic               is_cfg;
		logic [COUNT_W-1:0] count;
		hpgl_req_t          req;
		logic               known;
		hpgl_color_t        want;
	} script_row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [COUNT_W-1:0]  cfg_data;
	logic                in_valid;
	logic                in_ready;
	hpgl_req_t           in_data;
	logic                out_valid;
	logic                out_ready;
	hpgl_color_t         out_data;

	script_row_t         script[$];
	hpgl_entry_t         shade_table [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] shade_loaded;
	logic [COUNT_W-1:0]  count_reg;
	hpgl_color_t         pending_colors[$];
	int                  errors;
	int                  send_idle_pct;
	int                  recv_stall_pct;
	int                  hold_left;
	longint              cycles = 0;

	logic [COUNT_W-1:0] phase_counts [NUM_PHASES] =
		'{5'd16, 5'd31, 5'd1, 5'd0, 5'd2, 5'd17, 5'd9, 5'd4};

	hsv_palette_gradient_lookup_top #(
		.MAX_ENTRIES(NUM_SLOTS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	function automatic logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0] a, b,
			input int unsigned w);
		int unsigned acc;
		acc = a * (65536 - w) + b * w + 32768;
		return CH_W'(acc >> 16);
	endfunction

	// Shorter-arc blend; an exact half turn counts as negative, so it turns downward.
	function automatic logic [HUE_W-1:0] arc_blend(input logic [HUE_W-1:0] h0, h1,
			input int unsigned w);
		logic [HUE_W-1:0] diff;
		longint step;
		longint q;
		diff = h1 - h0;
		step = diff;
		if (diff[HUE_W-1])
			step = step - 65536;
		q = (step * longint'(w) + 32768) >>> 16;
		return h0 + q[HUE_W-1:0];
	endfunction

	function automatic hpgl_color_t predict_color(input logic [POS_W-1:0] pos);
		int unsigned n, f, m, p, idx, nxt;
		hpgl_entry_t e0, e1;
		hpgl_color_t c;
		c = '0;
		n = (count_reg > NUM_SLOTS) ? NUM_SLOTS : count_reg;
		if (n != 0) begin
			f = pos[FRAC_W-1:0];
			m = pos[FRAC_W] ? 65536 - f : f;
			p = m * n;
			// Only the mirrored end reaches the top; pull it back into the last entry.
			if (p >= (n << 16))
				p = (n << 16) - 1;
			idx = p >> 16;
			nxt = idx + 1;
			if (nxt >= n)
				nxt = 0;
			e0 = shade_table[idx];
			e1 = shade_table[nxt];
			c.color_hue = arc_blend(e0.hue, e1.hue, p & 32'hFFFF);
			c.color_sat = mix_channel(e0.sat, e1.sat, p & 32'hFFFF);
			c.color_val = mix_channel(e0.val, e1.val, p & 32'hFFFF);
		end
		return c;
	endfunction

	function automatic int unsigned edge_value(input int unsigned top);
		case ($urandom_range(4))
			0: return 0;
			1: return top;
			2: return (top + 1) / 2;
			default: return $urandom_range(top);
		endcase
	endfunction

	function automatic hpgl_req_t make_random_req();
		hpgl_req_t r;
		int unsigned n;
		int hole;
		n = (count_reg > NUM_SLOTS) ? NUM_SLOTS : count_reg;
		hole = -1;
		for (int i = NUM_SLOTS - 1; i >= 0; i--)
			if (i < int'(n) && !shade_loaded[i])
				hole = i;
		r.req_type    = ($urandom_range(99) < 25) ? REQ_WRITE : REQ_LOOKUP;
		r.position    = POS_W'($urandom_range(24'hFFFFFF));
		r.entry_index = IDX_W'($urandom_range(NUM_SLOTS - 1));
		r.entry_hue   = HUE_W'(edge_value(16'hFFFF));
		r.entry_sat   = CH_W'(edge_value(8'hFF));
		r.entry_val   = CH_W'(edge_value(8'hFF));
		// Entries in use must hold data before any lookup can read them.
		if (hole >= 0) begin
			r.req_type    = REQ_WRITE;
			r.entry_index = IDX_W'(hole);
		end
		// Opposite hue to the slot below makes the half-turn tie common.
		if (r.req_type == REQ_WRITE && $urandom_range(3) == 0)
			r.entry_hue = shade_table[r.entry_index - 1'b1].hue ^ 16'h8000;
		if (r.req_type == REQ_LOOKUP) begin
			case ($urandom_range(3))
				0: r.position[FRAC_W-1:0] = '0;
				1: r.position[FRAC_W-1:0] = $urandom_range(1) ? 16'hFFFF : 16'h0001;
				default: ;
			endcase
		end
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [HUE_W-1:0] want, got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
		end
	endtask

	task automatic check_color(input hpgl_color_t got);
		hpgl_color_t want;
		if (pending_colors.size() == 0) begin
			errors++;
			$display("%0t: unexpected item, expected none, got hue %h sat %h val %h",
				$time, got.color_hue, got.color_sat, got.color_val);
		end else begin
			want = pending_colors.pop_front();
			compare_field("color_hue", want.color_hue, got.color_hue);
			compare_field("color_sat", want.color_sat, got.color_sat);
			compare_field("color_val", want.color_val, got.color_val);
		end
	endtask

	task automatic record_accepted(input hpgl_req_t r, input logic known,
			input hpgl_color_t want);
		if (r.req_type == REQ_WRITE) begin
			shade_table[r.entry_index].hue = r.entry_hue;
			shade_table[r.entry_index].sat = r.entry_sat;
			shade_table[r.entry_index].val = r.entry_val;
			shade_loaded[r.entry_index] = 1'b1;
		end else begin
			pending_colors.push_back(known ? want : predict_color(r.position));
		end
	endtask

	task automatic send_req(input hpgl_req_t r, input logic known, input hpgl_color_t want);
		logic taken;
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		record_accepted(r, known, want);
	endtask

	task automatic write_count(input logic [COUNT_W-1:0] v);
		logic taken;
		in_valid <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		// Writes give no result and may still be in the pipeline.
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		count_reg = v;
	endtask

	task automatic cfg_row(input logic [COUNT_W-1:0] v);
		script_row_t row;
		row = '{1'b1, v, '0, 1'b0, '0};
		script.push_back(row);
	endtask

	task automatic write_row(input logic [IDX_W-1:0] idx, input logic [HUE_W-1:0] h,
			input logic [CH_W-1:0] s, v);
		script_row_t row;
		row = '{1'b0, '0, '0, 1'b0, '0};
		row.req = '{REQ_WRITE, {POS_W{1'b1}}, idx, h, s, v};
		script.push_back(row);
	endtask

	task automatic look_row(input logic [POS_W-1:0] pos, input logic known,
			input logic [HUE_W-1:0] h, input logic [CH_W-1:0] s, v);
		script_row_t row;
		row = '{1'b0, '0, '0, known, '0};
		row.req = '{REQ_LOOKUP, pos, {IDX_W{1'b1}}, {HUE_W{1'b1}}, {CH_W{1'b1}}, {CH_W{1'b1}}};
		row.want = '{h, s, v};
		script.push_back(row);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
			@(negedge clk);
			if (arst_n && out_valid && out_ready)
				check_color(out_data);
		end
	end

	initial begin
		logic [COUNT_W-1:0] next_count;
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		in_valid       = 1'b0;
		in_data        = '0;
		out_ready      = 1'b0;
		errors         = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = 0;
		count_reg      = '0;
		shade_loaded   = '0;
		foreach (shade_table[i])
			shade_table[i] = '0;

		// An empty palette answers black.
		look_row(24'h000000, 1'b1, 16'h0000, 8'h00, 8'h00);
		look_row(24'hFFFFFF, 1'b1, 16'h0000, 8'h00, 8'h00);
		write_row(4'd0, 16'h0000, 8'h00, 8'h00);
		write_row(4'd1, 16'h8000, 8'hFF, 8'hFF);
		write_row(4'd2, 16'hFFFF, 8'hFF, 8'h00);
		write_row(4'd3, 16'h0001, 8'h00, 8'hFF);
		write_row(4'd15, 16'h1234, 8'h5A, 8'hA5);
		cfg_row(5'd2);
		look_row(24'h000000, 1'b1, 16'h0000, 8'h00, 8'h00);
		look_row(24'h008000, 1'b1, 16'h8000, 8'hFF, 8'hFF);
		look_row(24'h010000, 1'b0, '0, '0, '0);
		look_row(24'h004000, 1'b0, '0, '0, '0);
		look_row(24'hFFFFFF, 1'b0, '0, '0, '0);
		look_row(24'hFE0000, 1'b1, 16'h0000, 8'h00, 8'h00);
		cfg_row(5'd4);
		look_row(24'h00C000, 1'b1, 16'h0001, 8'h00, 8'hFF);
		look_row(24'h00E000, 1'b0, '0, '0, '0);
		look_row(24'h00FFFF, 1'b0, '0, '0, '0);
		look_row(24'h000001, 1'b0, '0, '0, '0);
		write_row(4'd3, 16'h7FFF, 8'h80, 8'h01);
		look_row(24'h00C000, 1'b1, 16'h7FFF, 8'h80, 8'h01);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg)
				write_count(script[i].count);
			else
				send_req(script[i].req, script[i].known, script[i].want);
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			next_count = (ph == NUM_PHASES - 1) ? COUNT_W'($urandom_range(31)) : phase_counts[ph];
			write_count(next_count);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase
			// Long receiver hold-off while items keep coming, to back up the input.
			if (ph == 0)
				hold_left = HOLD_CYCLES;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == 1 && k == PHASE_ITEMS / 2) begin
					in_valid <= 1'b0;
					do @(posedge clk); while (pending_colors.size() != 0);
				end
				send_req(make_random_req(), 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && pending_colors.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
